[rtl/core/futex_wait_table_unit_defines.svh]
// Assertion helpers for the futex wait table engine (fwt_back).
// Each helper samples on clk_i and is disabled while rst_ni is low.
`ifndef FUTEX_WAIT_TABLE_UNIT_DEFINES_SVH
`define FUTEX_WAIT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FWT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FWT_ASSERT_NEXT(name, ante, cons, msg) \
  `FWT_ASSERT(name, (ante) |=> (cons), msg)
`else
`define FWT_ASSERT(name, prop, msg)
`define FWT_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/core/fwt_pkg.sv]
// ----------------------------------------------------------------------------
// fwt_pkg
// Types, field widths and codes shared by the futex wait table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int TASK_COUNT_DEF    = 64;
  localparam int ADDRESS_BITS_DEF  = 48;
  localparam int QUEUE_DEPTH       = 2;

  localparam int KIND_W    = 9;
  localparam int ADDR_W    = 48;
  localparam int VALUE_W   = 32;
  localparam int TASK_ID_W = 6;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 7;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 8;

  localparam int PRIVATE_BIT = 7;

  localparam logic [CMD_W-1:0] CMD_WAIT = 7'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE = 7'd1;

  localparam logic [VALUE_W-1:0] WAKE_ONE = 32'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_BLOCKED     = 3'd0,
    ST_WOKE        = 3'd1,
    ST_NONE        = 3'd2,
    ST_AGAIN       = 3'd3,
    ST_INVALID     = 3'd4,
    ST_UNSUPPORTED = 3'd5,
    ST_FULL        = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_WAIT   = 2'd1,
    OP_WAKE   = 2'd2
  } op_e;

  // One classified call on its way from the front end to the table engine.
  typedef struct packed {
    op_e                   op;
    status_e               status;
    logic [ADDR_W-1:0]     key;
    logic [TASK_ID_W-1:0]  task_id;
  } cmd_t;

endpackage

[rtl/core/futex_wait_table_unit.sv]
// ----------------------------------------------------------------------------
// futex_wait_table_unit
// Futex wait table: tracks waiting tasks per futex address and answers
// wait and wake calls one result word per call.
// ----------------------------------------------------------------------------
// Use: every call enters on the s_axis channel and gives exactly one result
// word on the m_axis channel, in call order. The op word travels in tuser.
// A front end classifies each call in the cycle it is taken and queues it
// (two deep); the table engine then handles one call at a time.
// Rejected calls (null address, private flag, unknown command, wake count
// other than one, value mismatch, task out of range) are answered from the
// idle state without a table access. A wait or a wake first scans the key
// memory one entry per cycle until the address matches or the last entry
// is read; a wake then searches the lowest waiter a byte a cycle.
// Reset empties the table at once (valid bits in flip-flops) and the queue.
// A stalled receiver holds the result word; calls are still taken until the
// queue is full, then s_axis_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module futex_wait_table_unit
  import fwt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TASK_COUNT    = TASK_COUNT_DEF,
  parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [47:0] address, [79:48] value, [111:80] current_value, [117:112] task_id
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [8:0] kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [5:0] woken_task
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  cmd_t                 front_cmd;
  cmd_t                 queue_cmd;
  logic                 queue_ready;
  logic                 queue_valid;
  logic                 queue_pop;
  logic [TASK_ID_W-1:0] woken_task;

  fwt_front #(
    .TASK_COUNT   (TASK_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .kind_i          (s_axis_tuser),
    .address_i       (s_axis_tdata[47:0]),
    .value_i         (s_axis_tdata[79:48]),
    .current_value_i (s_axis_tdata[111:80]),
    .task_id_i       (s_axis_tdata[117:112]),
    .cmd_o           (front_cmd)
  );

  fwt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid && queue_ready),
    .push_cmd_i (front_cmd),
    .ready_o    (queue_ready),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_cmd_o  (queue_cmd)
  );

  fwt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TASK_COUNT    (TASK_COUNT),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (m_axis_tuser),
    .res_task_o   (woken_task)
  );

  assign s_axis_tready = queue_ready;
  assign m_axis_tdata  = OUT_DATA_W'(woken_task);

endmodule

[rtl/core/fwt_ram.sv]
// ----------------------------------------------------------------------------
// fwt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fwt_front.sv]
// ----------------------------------------------------------------------------
// fwt_front
// Decodes a futex call and sorts out every call that needs no table access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwt_front
  import fwt_pkg::*;
#(
  parameter int TASK_COUNT   = TASK_COUNT_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [VALUE_W-1:0]   value_i,
  input  logic [VALUE_W-1:0]   current_value_i,
  input  logic [TASK_ID_W-1:0] task_id_i,
  output cmd_t                 cmd_o
);

  localparam int KEY_W = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam logic [TASK_ID_W:0] TaskLimit = (TASK_ID_W + 1)'(TASK_COUNT);

  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] key;

  assign cmd = kind_i[CMD_W-1:0];
  assign key = ADDR_W'(address_i[KEY_W-1:0]);

  always_comb begin
    cmd_o.op      = OP_REPORT;
    cmd_o.status  = ST_UNSUPPORTED;
    cmd_o.key     = key;
    cmd_o.task_id = task_id_i;
    if (key == '0) begin
      cmd_o.status = ST_INVALID;
    end else if (kind_i[PRIVATE_BIT]) begin
      cmd_o.status = ST_UNSUPPORTED;
    end else if (cmd == CMD_WAIT) begin
      if (value_i != current_value_i) begin
        cmd_o.status = ST_AGAIN;
      end else if ({1'b0, task_id_i} >= TaskLimit) begin
        cmd_o.status = ST_INVALID;
      end else begin
        cmd_o.op = OP_WAIT;
      end
    end else if (cmd == CMD_WAKE) begin
      if (value_i != WAKE_ONE) begin
        cmd_o.status = ST_UNSUPPORTED;
      end else begin
        cmd_o.op = OP_WAKE;
      end
    end
  end

endmodule

[rtl/core/fwt_queue.sv]
// ----------------------------------------------------------------------------
// fwt_queue
// Short first-in first-out queue of classified calls between the front end
// and the table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwt_queue
  import fwt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign ready_o   = (count_q != (PTR_W + 1)'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/fwt_back.sv]
// ----------------------------------------------------------------------------
// fwt_back
// Table engine: scans the key store, records waiters, releases the lowest
// waiter and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "futex_wait_table_unit_defines.svh"

module fwt_back
  import fwt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int TASK_COUNT    = TASK_COUNT_DEF,
  parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [STATUS_W-1:0]  res_status_o,
  output logic [TASK_ID_W-1:0] res_task_o
);

  localparam int KEY_W = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NCH   = (TASK_COUNT + 7) / 8;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PE_W  = NCH * 8;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_WREAD  = 5'b01000,
    S_PENC   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cmd_t                 cmd_q, cmd_d;
  logic [TABLE_ENTRIES-1:0] used_q, used_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 free_q, free_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [TASK_COUNT-1:0] word_q, word_d;
  logic [PE_W-1:0]      pe_q, pe_d;
  logic [CH_W-1:0]      chunk_q, chunk_d;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [TASK_ID_W-1:0] out_task_q, out_task_d;

  logic                 key_we;
  logic [IDX_W-1:0]     key_waddr;
  logic [IDX_W-1:0]     key_raddr;
  logic [KEY_W-1:0]     key_rdata;
  logic                 wt_we;
  logic [IDX_W-1:0]     wt_waddr;
  logic [TASK_COUNT-1:0] wt_wdata;
  logic [IDX_W-1:0]     wt_raddr;
  logic [TASK_COUNT-1:0] wt_rdata;

  logic                 match;
  logic                 last_entry;
  logic [2:0]           enc;
  logic [TASK_ID_W-1:0] wbit;
  logic [TASK_COUNT-1:0] task_bit;

  fwt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (cmd_q.key[KEY_W-1:0]),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  fwt_ram #(.WIDTH(TASK_COUNT), .DEPTH(TABLE_ENTRIES)) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wt_waddr),
    .wdata_i (wt_wdata),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  assign match      = used_q[cnt_q] && (key_rdata == cmd_q.key[KEY_W-1:0]);
  assign last_entry = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));
  assign task_bit   = TASK_COUNT'(1) << cmd_q.task_id;

  // Lowest set bit of the byte under inspection.
  always_comb begin
    enc = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pe_q[i]) begin
        enc = 3'(i);
      end
    end
  end

  assign wbit = TASK_ID_W'({chunk_q, enc});

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_task_o   = out_task_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    used_d       = used_q;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    word_d       = word_q;
    pe_d         = pe_q;
    chunk_d      = chunk_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_task_d   = out_task_q;
    cmd_pop_o    = 1'b0;
    key_we       = 1'b0;
    key_waddr    = free_idx_q;
    key_raddr    = '0;
    wt_we        = 1'b0;
    wt_waddr     = hit_idx_q;
    wt_wdata     = word_q;
    wt_raddr     = hit_idx_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (cmd_i.op == OP_REPORT) begin
            out_valid_d  = 1'b1;
            out_status_d = cmd_i.status;
            out_task_d   = '0;
          end else begin
            key_raddr = '0;
            cnt_d     = '0;
            hit_d     = 1'b0;
            free_d    = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        key_raddr = cnt_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = cnt_q;
        end
        if (!used_q[cnt_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = cnt_q;
        end
        if (match || last_entry) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (hit_q) begin
          wt_raddr = hit_idx_q;
          state_d  = S_WREAD;
        end else begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_task_d  = '0;
          if (cmd_q.op == OP_WAKE) begin
            out_status_d = ST_NONE;
          end else if (free_q) begin
            // New address: claim the first free entry with just this waiter.
            key_we             = 1'b1;
            key_waddr          = free_idx_q;
            wt_we              = 1'b1;
            wt_waddr           = free_idx_q;
            wt_wdata           = task_bit;
            used_d[free_idx_q] = 1'b1;
            out_status_d       = ST_BLOCKED;
          end else begin
            out_status_d = ST_FULL;
          end
        end
      end
      S_WREAD: begin
        if (cmd_q.op == OP_WAIT) begin
          wt_we        = 1'b1;
          wt_waddr     = hit_idx_q;
          wt_wdata     = wt_rdata | task_bit;
          out_valid_d  = 1'b1;
          out_status_d = ST_BLOCKED;
          out_task_d   = '0;
          state_d      = S_IDLE;
        end else begin
          word_d  = wt_rdata;
          pe_d    = PE_W'(wt_rdata);
          chunk_d = '0;
          state_d = S_PENC;
        end
      end
      S_PENC: begin
        if (pe_q[7:0] != 8'd0) begin
          wt_we        = 1'b1;
          wt_waddr     = hit_idx_q;
          wt_wdata     = word_q & ~(TASK_COUNT'(1) << wbit);
          out_valid_d  = 1'b1;
          out_status_d = ST_WOKE;
          out_task_d   = wbit;
          state_d      = S_IDLE;
        end else if (chunk_q == CH_W'(NCH - 1)) begin
          // Nobody left waiting on this address: release the entry.
          used_d[hit_idx_q] = 1'b0;
          out_valid_d       = 1'b1;
          out_status_d      = ST_NONE;
          out_task_d        = '0;
          state_d           = S_IDLE;
        end else begin
          pe_d    = pe_q >> 8;
          chunk_d = chunk_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    cnt_q        <= cnt_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    word_q       <= word_d;
    pe_q         <= pe_d;
    chunk_q      <= chunk_d;
    out_status_q <= out_status_d;
    out_task_q   <= out_task_d;
  end

  `FWT_ASSERT(a_pop_slot_free, cmd_pop_o |-> !out_valid_q, "call taken while result pending")
  `FWT_ASSERT(a_hit_entry_used, (state_q == S_WREAD) |-> used_q[hit_idx_q], "hit entry not in use")
  `FWT_ASSERT(a_woke_bit_set, (state_q == S_PENC) && (pe_q[7:0] != 8'd0) |-> word_q[wbit],
              "released task was not waiting")
  `FWT_ASSERT_NEXT(a_busy_no_result, (state_q != S_IDLE) && !out_valid_q && (state_d != S_IDLE),
                   !out_valid_q, "result raised before the call finished")

endmodule

[test/futex_wait_table_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// futex_wait_table_unit_tb
// Self-checking bench for the futex wait table unit.
// ----------------------------------------------------------------------------
// Futex calls go in on the slave stream and their result words come back on
// the master stream. A scoreboard keeps its own copy of the address table
// and the waiter bitmaps and predicts every result word. The run starts with
// a set of hand-picked calls. Random calls follow, most of them well formed
// and aimed at a small pool of addresses, so the table fills and drains. The
// random calls go through several idling phases, and one long receiver
// hold-off backs the block up.
// ----------------------------------------------------------------------------

module futex_wait_table_unit_tb;
  import fwt_pkg::*;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          POOL_SIZE    = 24;
  localparam int          PHASE_CALLS  = 425;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 40;

  localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 7'd2;
  localparam logic [CMD_W-1:0]  CMD_TOP     = 7'h7F;
  localparam logic [KIND_W-1:0] KIND_WAIT   = {2'b00, CMD_WAIT};
  localparam logic [KIND_W-1:0] KIND_WAKE   = {2'b00, CMD_WAKE};
  localparam logic [KIND_W-1:0] FLAG_PRIV   = KIND_W'(1) << PRIVATE_BIT;
  localparam logic [KIND_W-1:0] FLAG_RT     = KIND_W'(1) << (KIND_W - 1);

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    addr;
    logic [VALUE_W-1:0]   value;
    logic [VALUE_W-1:0]   cur_value;
    logic [TASK_ID_W-1:0] task_id;
  } call_t;

  typedef struct {
    status_e              status;
    logic [TASK_ID_W-1:0] woken;
  } reply_t;

  // Mirror of the wait table, with the queue of result words still owed.
  class futex_table_board;
    bit                   used[TABLE_ENTRIES_DEF];
    logic [ADDR_W-1:0]    keys[TABLE_ENTRIES_DEF];
    logic [63:0]          waiters[TABLE_ENTRIES_DEF];
    reply_t               owed[$];
    int unsigned          fail_count;

    function int lookup(logic [ADDR_W-1:0] addr);
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
        if (used[i] && keys[i] == addr) return i;
      end
      return -1;
    endfunction

    function status_e do_wait(call_t c);
      int e;
      if (c.value != c.cur_value) return ST_AGAIN;
      if (int'(c.task_id) >= TASK_COUNT_DEF) return ST_INVALID;
      e = lookup(c.addr);
      if (e < 0) begin
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
          if (!used[i]) begin
            e = i;
            break;
          end
        end
        if (e < 0) return ST_FULL;
        used[e]    = 1'b1;
        keys[e]    = c.addr;
        waiters[e] = '0;
      end
      waiters[e][c.task_id] = 1'b1;
      return ST_BLOCKED;
    endfunction

    function status_e do_wake(call_t c, output logic [TASK_ID_W-1:0] woken);
      int e;
      e = lookup(c.addr);
      woken = '0;
      if (e < 0) return ST_NONE;
      for (int t = 0; t < TASK_COUNT_DEF; t++) begin
        if (waiters[e][t]) begin
          waiters[e][t] = 1'b0;
          woken = TASK_ID_W'(t);
          return ST_WOKE;
        end
      end
      // A wake that finds the entry empty releases it.
      used[e] = 1'b0;
      return ST_NONE;
    endfunction

    function void note_call(call_t c);
      reply_t r;
      logic [CMD_W-1:0] cmd;
      cmd     = c.kind[CMD_W-1:0];
      r.woken = '0;
      if (c.addr == '0) r.status = ST_INVALID;
      else if (c.kind[PRIVATE_BIT]) r.status = ST_UNSUPPORTED;
      else if (cmd == CMD_WAIT) r.status = do_wait(c);
      else if (cmd == CMD_WAKE) begin
        if (c.value != WAKE_ONE) r.status = ST_UNSUPPORTED;
        else r.status = do_wake(c, r.woken);
      end else r.status = ST_UNSUPPORTED;
      owed.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [TASK_ID_W-1:0] woken);
      reply_t r;
      if (owed.size() == 0) begin
        $error("unexpected result word: status %0d, woken_task %0d", status, woken);
        fail_count++;
        return;
      end
      r = owed.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d (%s), got %0d", r.status, r.status.name(), status);
        fail_count++;
      end
      if (woken !== r.woken) begin
        $error("woken_task: expected %0d, got %0d", r.woken, woken);
        fail_count++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  futex_table_board      board = new();
  logic [ADDR_W-1:0]     addr_pool[POOL_SIZE];
  int                    send_idle_pct;
  int                    recv_stall_pct;
  bit                    hold_req;
  int                    cycle_count;

  futex_wait_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic call_t make_call(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                      logic [VALUE_W-1:0] value,
                                      logic [VALUE_W-1:0] cur_value,
                                      logic [TASK_ID_W-1:0] task_id);
    call_t c;
    c.kind      = kind;
    c.addr      = addr;
    c.value     = value;
    c.cur_value = cur_value;
    c.task_id   = task_id;
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] random_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Mostly well-formed waits and wakes on the address pool; the rest is noise.
  function automatic call_t random_call();
    call_t c;
    int    pick;
    pick        = $urandom_range(99);
    c.addr      = addr_pool[$urandom_range(POOL_SIZE - 1)];
    c.value     = $urandom;
    c.cur_value = c.value;
    c.task_id   = $urandom_range(1) ? TASK_ID_W'($urandom_range(63)) :
                                      TASK_ID_W'($urandom_range(7));
    if (pick < 46) begin
      c.kind = KIND_WAIT | ($urandom_range(1) ? FLAG_RT : '0);
    end else if (pick < 86) begin
      c.kind  = KIND_WAKE | ($urandom_range(1) ? FLAG_RT : '0);
      c.value = WAKE_ONE;
    end else begin
      c.kind      = $urandom_range(3) == 0 ? KIND_W'($urandom) :
                    ($urandom_range(1) ? KIND_WAIT : KIND_WAKE);
      c.cur_value = $urandom_range(1) ? c.value : VALUE_W'($urandom);
      case ($urandom_range(3))
        0: c.addr = '0;
        1: c.addr = random_addr();
        default: ;
      endcase
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the handshake.
  task automatic send_call(call_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c.task_id, c.cur_value, c.value, c.addr};
    s_axis_tuser  <= c.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_call(c);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tuser, m_axis_tdata[TASK_ID_W-1:0]);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] top_addr;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    top_addr       = '1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      do addr_pool[i] = random_addr(); while (addr_pool[i] == '0);
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Rejections in check order: null address, private flag, command, wake count; then a value mismatch.
    send_call(make_call(KIND_W'('1), '0, 32'd5, 32'd5, 6'd1));
    send_call(make_call(KIND_WAIT | FLAG_PRIV, top_addr, 32'd0, 32'd0, 6'd2));
    send_call(make_call({2'b00, CMD_UNKNOWN}, top_addr, 32'd1, 32'd1, 6'd3));
    send_call(make_call({2'b00, CMD_TOP}, top_addr, 32'd1, 32'd1, 6'd3));
    send_call(make_call(KIND_WAKE, top_addr, 32'd0, 32'd0, 6'd0));
    send_call(make_call(KIND_WAKE, top_addr, 32'hFFFF_FFFF, 32'd0, 6'd0));
    send_call(make_call(KIND_WAIT, top_addr, 32'h8000_0000, 32'h7FFF_FFFF, 6'd4));

    // Waiters on the highest address, a repeated wait, then wake until freed.
    send_call(make_call(KIND_WAIT | FLAG_RT, top_addr, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
    send_call(make_call(KIND_WAIT, top_addr, 32'h8000_0000, 32'h8000_0000, 6'd0));
    send_call(make_call(KIND_WAIT, top_addr, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd63));
    send_call(make_call(KIND_WAKE | FLAG_RT, top_addr, WAKE_ONE, 32'd0, 6'd0));
    send_call(make_call(KIND_WAKE, top_addr, WAKE_ONE, 32'd0, 6'd0));
    send_call(make_call(KIND_WAKE, top_addr, WAKE_ONE, 32'd0, 6'd0));
    send_call(make_call(KIND_WAKE, top_addr, WAKE_ONE, 32'd0, 6'd0));

    // Fill the table from the pool, then a wait on one more address finds no room.
    for (int i = 0; i <= TABLE_ENTRIES_DEF; i++) begin
      send_call(make_call(KIND_WAIT, addr_pool[i], VALUE_W'(i), VALUE_W'(i),
                          TASK_ID_W'(i)));
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          // The last word has been taken; drop valid while the hold-off is armed.
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          hold_req = 1'b1;
          @(negedge clk_i);
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      for (int n = 0; n < PHASE_CALLS; n++) send_call(random_call());
    end

    s_axis_tvalid  <= 1'b0;
    recv_stall_pct = 0;
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fwt_pkg.sv
rtl/core/fwt_ram.sv
rtl/core/fwt_front.sv
rtl/core/fwt_queue.sv
rtl/core/fwt_back.sv
rtl/core/futex_wait_table_unit.sv
test/futex_wait_table_unit_tb.sv
